// File: sv/pps_pkg.sv
// Package with the constants, types and codes of the preemptive priority scheduler.
`default_nettype none
package pps_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int ID_W      = 8;
	localparam int TIME_W    = 16;
	localparam int PRIO_W    = 8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ID_W-1:0]   id_t;
	typedef logic [TIME_W-1:0] time_t;
	typedef logic [PRIO_W-1:0] prio_t;

	// Input request
	typedef struct packed {
		logic  op;
		id_t   task_id;
		time_t arrival;
		prio_t priority_req;
		time_t burst;
	} req_t;

	// Result of one request
	typedef struct packed {
		logic  ran;
		id_t   running_id;
		logic  finished;
		time_t finish_time;
		time_t time_now;
		logic  all_done;
		logic  load_rejected;
	} rsp_t;

	// Best candidate handed from cell to cell during a scan
	typedef struct packed {
		logic  have;
		idx_t  idx;
		id_t   id;
		prio_t prio;
		time_t arrival;
		time_t remaining;
	} token_t;

	// Load and decrement commands broadcast to the cells
	typedef struct packed {
		logic  ld_en;
		logic  dec_en;
		idx_t  idx;
		id_t   id;
		time_t arrival;
		prio_t prio;
		time_t burst;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// File: sv/pps_if.sv
// Valid/ready channel interfaces for scheduler requests and results.
`default_nettype none
interface pps_req_if;
	import pps_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pps_rsp_if;
	import pps_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/pps_cell.sv
// One task table cell: holds one entry and passes the best candidate to its neighbor.
`default_nettype none
module pps_cell (
	input  wire              clk,
	input  wire              arst_n,
	input  pps_pkg::idx_t    my_idx,
	input  pps_pkg::time_t   cur_time,
	input  pps_pkg::cell_ctl_t ctl,
	input  pps_pkg::token_t  tok_in,
	output pps_pkg::token_t  tok_out
);
	import pps_pkg::*;

	logic   valid_q;
	id_t    id_q;
	time_t  arrival_q;
	prio_t  prio_q;
	time_t  remaining_q;
	token_t tok_q;
	logic   hit;
	logic   cand;
	logic   better;
	token_t mine;

	assign hit = (ctl.idx == my_idx);

	// Mark the cell loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ld_en && hit) begin
			valid_q <= 1'b1;
		end
	end

	// Write the entry on load, drop the remaining burst when it runs
	always_ff @(posedge clk) begin
		if (ctl.ld_en && hit) begin
			id_q        <= ctl.id;
			arrival_q   <= ctl.arrival;
			prio_q      <= ctl.prio;
			remaining_q <= ctl.burst;
		end else if (ctl.dec_en && hit) begin
			remaining_q <= remaining_q - 16'd1;
		end
	end

	// Compare this entry against the incoming candidate
	always_comb begin
		cand   = valid_q && (remaining_q != '0) && !(arrival_q > cur_time);
		better = !tok_in.have || (prio_q < tok_in.prio) ||
			((prio_q == tok_in.prio) && (arrival_q < tok_in.arrival));
		mine.have      = 1'b1;
		mine.idx       = my_idx;
		mine.id        = id_q;
		mine.prio      = prio_q;
		mine.arrival   = arrival_q;
		mine.remaining = remaining_q;
	end

	// Hand the winner so far to the next cell
	always_ff @(posedge clk) begin
		tok_q <= (cand && better) ? mine : tok_in;
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

// File: sv/preemptive_priority_scheduler_core.sv
// Preemptive priority scheduler: a row of task cells scanned by a passing candidate token.
// Load request: result held at the accepting edge, then moved to the output register in ST_DONE
// once the output is free. Tick request: the token steps one cell per cycle during ST_SCAN, then
// ST_APPLY updates the winner and ST_DONE moves the result out. Requests are taken only in ST_IDLE.
// A new request is taken while the previous result still waits on the output.
// Reset clears the loaded count, the current time and the cell valid bits; entry data is unset.
`default_nettype none
module preemptive_priority_scheduler_core (
	input wire      clk,
	input wire      arst_n,
	pps_req_if.sink   item,
	pps_rsp_if.source result
);
	import pps_pkg::*;

	state_t    state_q;
	state_t    state_nxt;
	cnt_t      loaded_q;
	cnt_t      alive_q;
	cnt_t      alive_nxt;
	time_t     time_q;
	idx_t      scan_q;
	rsp_t      res_q;
	rsp_t      res_nxt;
	rsp_t      out_q;
	logic      out_valid_q;
	logic      accept;
	logic      full;
	logic      finish;
	logic      out_free;
	cell_ctl_t ctl;
	token_t    tok_empty;
	token_t    tok_in  [MAX_TASKS];
	token_t    tok_out [MAX_TASKS];
	token_t    tok_last;

	assign accept   = item.valid && item.ready;
	assign full     = (loaded_q == CNT_W'(MAX_TASKS));
	assign tok_last = tok_out[MAX_TASKS-1];
	assign finish   = tok_last.have && (tok_last.remaining == 16'd1);
	assign out_free = !out_valid_q || result.ready;

	// Build the row of cells
	assign tok_empty = '0;
	for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign tok_in[g] = tok_empty;
		end else begin : g_link
			assign tok_in[g] = tok_out[g-1];
		end
		pps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.my_idx   (IDX_W'(g)),
			.cur_time (time_q),
			.ctl      (ctl),
			.tok_in   (tok_in[g]),
			.tok_out  (tok_out[g])
		);
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					state_nxt = (item.data.op == OP_TICK) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_q == IDX_W'(MAX_TASKS - 1)) begin
					state_nxt = ST_APPLY;
				end
			end
			ST_APPLY: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs: handshake, cell commands and the result
	always_comb begin
		item.ready  = (state_q == ST_IDLE);
		ctl.ld_en   = accept && (item.data.op == OP_LOAD) && !full;
		ctl.dec_en  = (state_q == ST_APPLY) && tok_last.have;
		ctl.idx     = (state_q == ST_APPLY) ? tok_last.idx : loaded_q[IDX_W-1:0];
		ctl.id      = item.data.task_id;
		ctl.arrival = item.data.arrival;
		ctl.prio    = item.data.priority_req;
		ctl.burst   = item.data.burst;

		alive_nxt = alive_q;
		res_nxt   = '0;
		if (state_q == ST_APPLY) begin
			if (finish) begin
				alive_nxt = alive_q - CNT_W'(1);
			end
			res_nxt.ran         = tok_last.have;
			res_nxt.running_id  = tok_last.have ? tok_last.id : '0;
			res_nxt.finished    = finish;
			res_nxt.finish_time = finish ? (time_q + 16'd1) : '0;
			res_nxt.time_now    = time_q + 16'd1;
		end else begin
			if (ctl.ld_en && (item.data.burst != '0)) begin
				alive_nxt = alive_q + CNT_W'(1);
			end
			res_nxt.time_now      = time_q;
			res_nxt.load_rejected = full;
		end
		res_nxt.all_done = (alive_nxt == '0);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			loaded_q    <= '0;
			alive_q     <= '0;
			time_q      <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.ld_en) begin
				loaded_q <= loaded_q + CNT_W'(1);
			end
			if (ctl.ld_en || (state_q == ST_APPLY)) begin
				alive_q <= alive_nxt;
			end
			if (state_q == ST_APPLY) begin
				time_q <= time_q + 16'd1;
			end
			if (state_q == ST_SCAN) begin
				scan_q <= scan_q + IDX_W'(1);
			end else begin
				scan_q <= '0;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the pending result and the output register
	always_ff @(posedge clk) begin
		if ((accept && (item.data.op == OP_LOAD)) || (state_q == ST_APPLY)) begin
			res_q <= res_nxt;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_q <= res_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	a_alive_le_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		alive_q <= loaded_q)
		else $error("more unfinished tasks than loaded tasks");

	a_loaded_max: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= CNT_W'(MAX_TASKS))
		else $error("task table count beyond capacity");

	a_apply_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |-> ($past(state_q) == ST_SCAN))
		else $error("apply step without a finished scan");

	a_finish_drops_alive: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_APPLY) && finish) |=> (alive_q == $past(alive_q) - CNT_W'(1)))
		else $error("finished task not removed from unfinished count");

	a_time_steps_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |=> (time_q == $past(time_q) + 16'd1))
		else $error("time did not advance on tick");

endmodule
`default_nettype wire
